// File: rtl/mnpm_pkg.sv
// ----------------------------------------------------------------------------
// mnpm_pkg
// Shared widths, codes and controller/datapath interface types for the
// mutual neighbor pair matcher.
// ----------------------------------------------------------------------------
package mnpm_pkg;

  localparam int NODE_W = 10;
  localparam int ID_W   = NODE_W + 1;
  localparam int NODES  = 1 << NODE_W;

  // signed id that means no neighbor / no group
  localparam logic [ID_W-1:0] NONE_ID = {ID_W{1'b1}};

  localparam int IN_DATA_W  = NODE_W + 2 * ID_W;
  localparam int OUT_DATA_W = NODE_W + 2 * ID_W;

  typedef enum logic [1:0] {
    ACT_LOAD  = 2'd0,
    ACT_MATCH = 2'd1,
    ACT_READ  = 2'd2,
    ACT_SPARE = 2'd3
  } action_t;

  typedef enum logic [2:0] {
    OUT_LOADED  = 3'd0,
    OUT_PAIRED  = 3'd1,
    OUT_GROUPED = 3'd2,
    OUT_NOMATCH = 3'd3,
    OUT_READ    = 3'd4
  } outcome_t;

  typedef struct packed {
    logic take;  // input transfer this cycle
    logic look;  // own entries are in the read registers
    logic peer;  // neighbor's entry is in the read register
    logic fin;   // write the partner's group
    logic push;  // move result into the output register
  } cmd_t;

  typedef struct packed {
    logic is_load;    // incoming item is a load
    logic cur_match;  // item in work is a match
    logic grouped;    // node already has a group
    logic no_nb;      // node has no usable neighbor
    logic mutual;     // neighbor points back and node index is not above the neighbor's
    logic slot_free;  // output register can take a result
  } stat_t;

endpackage

// File: rtl/mnpm_datapath.sv
// ----------------------------------------------------------------------------
// mnpm_datapath
// Neighbor and group stores, read registers, result and output registers.
// ----------------------------------------------------------------------------
module mnpm_datapath (
  input  logic                         clk,
  input  logic                         rst,
  input  mnpm_pkg::cmd_t               cmd,
  output mnpm_pkg::stat_t              stat,
  input  logic [mnpm_pkg::IN_DATA_W-1:0]  s_tdata,
  input  logic [1:0]                   s_tuser,
  output logic                         m_tvalid,
  input  logic                         m_tready,
  output logic [mnpm_pkg::OUT_DATA_W-1:0] m_tdata,
  output logic [2:0]                   m_tuser
);
  import mnpm_pkg::*;

  logic [ID_W-1:0] nb_mem  [NODES];
  logic [ID_W-1:0] grp_mem [NODES];

  logic [NODE_W-1:0] in_node;
  logic [ID_W-1:0]   in_nb;
  logic [ID_W-1:0]   in_grp;
  action_t           act;

  logic [NODE_W-1:0] cur_node;
  logic              cur_match;
  logic [ID_W-1:0]   rd_nb;
  logic [ID_W-1:0]   rd_grp;
  logic [ID_W-1:0]   nb;

  logic [ID_W-1:0]   res_group;
  logic [ID_W-1:0]   res_partner;
  outcome_t          res_outcome;

  logic [NODE_W-1:0] out_node;
  logic [ID_W-1:0]   out_group;
  logic [ID_W-1:0]   out_partner;
  outcome_t          out_outcome;
  logic              out_valid;

  logic              is_load;
  logic              grp_we;
  logic [NODE_W-1:0] grp_waddr;
  logic [ID_W-1:0]   grp_wdata;
  logic [NODE_W-1:0] nb_raddr;

  assign in_node = s_tdata[NODE_W-1:0];
  assign in_nb   = s_tdata[NODE_W+ID_W-1:NODE_W];
  assign in_grp  = s_tdata[NODE_W+2*ID_W-1:NODE_W+ID_W];
  assign act     = action_t'(s_tuser);
  assign is_load = (act == ACT_LOAD);

  // group store has one write port: load, own entry on a pair, then partner
  always_comb begin
    grp_we    = 1'b0;
    grp_waddr = cur_node;
    grp_wdata = {1'b0, cur_node};
    if (cmd.take && is_load) begin
      grp_we    = 1'b1;
      grp_waddr = in_node;
      grp_wdata = in_grp;
    end else if (cmd.peer && stat.mutual) begin
      grp_we    = 1'b1;
    end else if (cmd.fin) begin
      grp_we    = 1'b1;
      grp_waddr = nb[NODE_W-1:0];
    end
  end

  assign nb_raddr = cmd.take ? in_node : rd_nb[NODE_W-1:0];

  always_ff @(posedge clk) begin
    if (cmd.take && is_load) begin
      nb_mem[in_node] <= in_nb;
    end
    if (grp_we) begin
      grp_mem[grp_waddr] <= grp_wdata;
    end
    if (cmd.take || cmd.look) begin
      rd_nb <= nb_mem[nb_raddr];
    end
    if (cmd.take) begin
      rd_grp <= grp_mem[in_node];
    end
  end

  always_comb begin
    stat.is_load   = is_load;
    stat.cur_match = cur_match;
    stat.grouped   = (rd_grp != NONE_ID);
    stat.no_nb     = rd_nb[ID_W-1];
    stat.mutual    = (rd_nb == {1'b0, cur_node}) && (cur_node <= nb[NODE_W-1:0]);
    stat.slot_free = !out_valid || m_tready;
  end

  // item and result registers
  always_ff @(posedge clk) begin
    if (cmd.take) begin
      cur_node  <= in_node;
      cur_match <= (act == ACT_MATCH);
      if (is_load) begin
        res_group   <= in_grp;
        res_partner <= NONE_ID;
        res_outcome <= OUT_LOADED;
      end
    end
    if (cmd.look) begin
      nb          <= rd_nb;
      res_group   <= rd_grp;
      res_partner <= NONE_ID;
      if (!cur_match) begin
        res_outcome <= OUT_READ;
      end else if (stat.grouped) begin
        res_outcome <= OUT_GROUPED;
      end else begin
        res_outcome <= OUT_NOMATCH;
      end
    end
    if (cmd.peer && stat.mutual) begin
      res_group   <= {1'b0, cur_node};
      res_partner <= nb;
      res_outcome <= OUT_PAIRED;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.push) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.push) begin
      out_node    <= cur_node;
      out_group   <= res_group;
      out_partner <= res_partner;
      out_outcome <= res_outcome;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {out_partner, out_group, out_node};
  assign m_tuser  = out_outcome;

endmodule

// File: rtl/mnpm_ctrl.sv
// ----------------------------------------------------------------------------
// mnpm_ctrl
// Sequencer for one action at a time: look up, check the peer, write back,
// hand the result to the output register.
// ----------------------------------------------------------------------------
module mnpm_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            s_tvalid,
  output logic            s_tready,
  input  mnpm_pkg::stat_t stat,
  output mnpm_pkg::cmd_t  cmd
);
  import mnpm_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOOK,
    ST_PEER,
    ST_FIN,
    ST_PUSH
  } state_t;

  state_t state;
  logic   take;

  assign s_tready = !rst &&
                    ((state == ST_IDLE) || ((state == ST_PUSH) && stat.slot_free));
  assign take     = s_tvalid && s_tready;

  always_comb begin
    cmd.take = take;
    cmd.look = (state == ST_LOOK);
    cmd.peer = (state == ST_PEER);
    cmd.fin  = (state == ST_FIN);
    cmd.push = (state == ST_PUSH) && stat.slot_free;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (take) begin
            state <= stat.is_load ? ST_PUSH : ST_LOOK;
          end
        end
        ST_LOOK: begin
          if (!stat.cur_match || stat.grouped || stat.no_nb) begin
            state <= ST_PUSH;
          end else begin
            state <= ST_PEER;
          end
        end
        ST_PEER: begin
          state <= stat.mutual ? ST_FIN : ST_PUSH;
        end
        ST_FIN: begin
          state <= ST_PUSH;
        end
        ST_PUSH: begin
          if (stat.slot_free) begin
            if (take) begin
              state <= stat.is_load ? ST_PUSH : ST_LOOK;
            end else begin
              state <= ST_IDLE;
            end
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

// File: rtl/mutual_neighbor_pair_matcher.sv
// ----------------------------------------------------------------------------
// mutual_neighbor_pair_matcher
// Per-node neighbor and group tables with load, match and read actions.
// ----------------------------------------------------------------------------
// usage:
//   s_axis carries one action per transfer: tuser is the action code,
//   tdata holds node, neighbor and initial group. m_axis returns exactly one
//   result per action: tuser is the outcome, tdata holds node, group, partner.
//   for a full matching sweep issue match actions in ascending node order.
// steps, from input transfer to result in the output register: a load pushes;
//   a read looks up, then pushes; a match looks up and pushes if grouped or with
//   no neighbor, else checks the peer and pushes if not mutual, else writes its
//   own group entry, then the partner's through the single write port, then pushes.
//   the sequencer works on one action at a time; a new action is taken in the
//   cycle the prior result is pushed, so loads stream at one per cycle unless stalled.
// reset clears the sequencer and the output valid; the tables are not
//   cleared, so every node must be loaded before it is matched or read.
// when the receiver stalls, the result waits in the output register and the
//   next action waits with tready low until that register frees up.
// ----------------------------------------------------------------------------
module mutual_neighbor_pair_matcher (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,   // node[9:0], neighbor_in[20:10], group_in[31:21]
  input  logic [1:0]  s_axis_tuser,   // action[1:0]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,   // node_out[9:0], group_out[20:10], partner[31:21]
  output logic [2:0]  m_axis_tuser    // outcome[2:0]
);
  import mnpm_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  mnpm_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_axis_tvalid),
    .s_tready (s_axis_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  mnpm_datapath u_dp (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .stat     (stat),
    .s_tdata  (s_axis_tdata),
    .s_tuser  (s_axis_tuser),
    .m_tvalid (m_axis_tvalid),
    .m_tready (m_axis_tready),
    .m_tdata  (m_axis_tdata),
    .m_tuser  (m_axis_tuser)
  );

endmodule

// File: rtl/mnpm_checker.sv
// ----------------------------------------------------------------------------
// mnpm_checker
// Port-level checks on the result channel of the pair matcher.
// ----------------------------------------------------------------------------
module mnpm_checker (
  input logic        clk,
  input logic        rst,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [31:0] m_axis_tdata,
  input logic [2:0]  m_axis_tuser
);
  import mnpm_pkg::*;

  // a stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("result changed while stalled");

  // no result straight out of reset
  a_rst: assert property (@(posedge clk) rst |=> !m_axis_tvalid)
    else $error("result valid after reset");

  // a pair names the node as its group and a real partner
  a_pair: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && (m_axis_tuser == OUT_PAIRED) |->
      (m_axis_tdata[20:10] == {1'b0, m_axis_tdata[9:0]}) && !m_axis_tdata[31])
    else $error("bad pair result");

  // every other outcome has no partner
  a_nopart: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && (m_axis_tuser != OUT_PAIRED) |-> (m_axis_tdata[31:21] == NONE_ID))
    else $error("partner on unpaired result");

endmodule

bind mutual_neighbor_pair_matcher mnpm_checker u_mnpm_checker (
  .clk           (clk),
  .rst           (rst),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);
